/* hdl/ert_pkg.sv */
// Shared types, codes and constants of the ECAM range table.
package ert_pkg;

  // Default table depth.
  localparam int MAX_RANGES_DEF = 16;

  // Field widths.
  localparam int ADDR_W    = 64;
  localparam int ALIGN_W   = 20;
  localparam int BASE_HI_W = ADDR_W - ALIGN_W;
  localparam int SEG_W     = 16;
  localparam int BUS_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;

  // Operation codes.
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

  // Transaction token handed from cell to cell.
  typedef struct packed {
    logic                 valid;
    logic [1:0]           mode;
    logic                 bad;
    logic [BASE_HI_W-1:0] base_hi;
    logic [SEG_W-1:0]     seg;
    logic [BUS_W-1:0]     sbus;
    logic [BUS_W-1:0]     ebus;
    logic [BUS_W-1:0]     bus;
    logic [BUS_W-1:0]     idx;
    logic                 clash;
    logic                 hit;
    logic [BASE_HI_W-1:0] hit_base;
    logic [SEG_W-1:0]     hit_seg;
    logic [BUS_W-1:0]     hit_sbus;
    logic [BUS_W-1:0]     hit_ebus;
  } carry_t;

  // Entry written into a cell.
  typedef struct packed {
    logic [BASE_HI_W-1:0] base_hi;
    logic [SEG_W-1:0]     seg;
    logic [BUS_W-1:0]     sbus;
    logic [BUS_W-1:0]     ebus;
  } entry_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic advance;
    logic occupied;
    logic wr_sel;
  } cell_ctl_t;

endpackage

/* hdl/ert_cell.sv */
// One table cell: holds one entry and checks the passing token against it.
module ert_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  ert_pkg::cell_ctl_t ctl,
  input  ert_pkg::entry_t   wr_entry,
  input  ert_pkg::carry_t   carry_in,
  output ert_pkg::carry_t   carry_out
);

  ert_pkg::entry_t entry;
  ert_pkg::carry_t carry_next;
  logic            seg_match;

  // Store a new entry when selected.
  always_ff @(posedge clk) begin
    if (ctl.wr_sel) begin
      entry <= wr_entry;
    end
  end

  // Compare the token with the stored entry.
  always_comb begin
    carry_next = carry_in;
    seg_match  = (entry.seg == carry_in.seg);
    if (carry_in.valid && ctl.occupied) begin
      case (carry_in.mode)
        ert_pkg::MODE_INSERT: begin
          if (seg_match && (carry_in.sbus <= entry.ebus) && (entry.sbus <= carry_in.ebus)) begin
            carry_next.clash = 1'b1;
          end
        end
        ert_pkg::MODE_LOOKUP: begin
          if (!carry_in.hit && seg_match && (carry_in.bus >= entry.sbus) &&
              (carry_in.bus <= entry.ebus)) begin
            carry_next.hit      = 1'b1;
            carry_next.hit_base = entry.base_hi;
            carry_next.hit_seg  = entry.seg;
            carry_next.hit_sbus = entry.sbus;
            carry_next.hit_ebus = entry.ebus;
          end
        end
        ert_pkg::MODE_READ: begin
          if (carry_in.idx == ert_pkg::BUS_W'(IDX)) begin
            carry_next.hit      = 1'b1;
            carry_next.hit_base = entry.base_hi;
            carry_next.hit_seg  = entry.seg;
            carry_next.hit_sbus = entry.sbus;
            carry_next.hit_ebus = entry.ebus;
          end
        end
        default: begin
          carry_next = carry_in;
        end
      endcase
    end
  end

  // Hand the token to the next cell; hold while the chain is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
    end else if (ctl.advance) begin
      carry_out <= carry_next;
    end
  end

endmodule

/* hdl/ecam_range_table.sv */
// Each transaction walks the cell chain one cell per cycle; the next one is taken
// once the result leaves the chain end, so the table takes no new transaction while
// one is in the chain.
// A stall at the output holds the token at the chain end and delays further input.
// Reset clears the entry count, the full mark and all in-flight tokens; entries
// themselves are not cleared and are only read below the entry count.
module ecam_range_table #(
  parameter int MAX_RANGES = ert_pkg::MAX_RANGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      mode,
  input  logic [ert_pkg::ADDR_W-1:0]      base_addr,
  input  logic [ert_pkg::SEG_W-1:0]       segment,
  input  logic [ert_pkg::BUS_W-1:0]       first_bus,
  input  logic [ert_pkg::BUS_W-1:0]       end_bus,
  input  logic [ert_pkg::BUS_W-1:0]       bus,
  input  logic [ert_pkg::BUS_W-1:0]       index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ert_pkg::STATUS_W-1:0]    status,
  output logic [ert_pkg::ADDR_W-1:0]      out_base,
  output logic [ert_pkg::SEG_W-1:0]       out_segment,
  output logic [ert_pkg::BUS_W-1:0]       out_start_bus,
  output logic [ert_pkg::BUS_W-1:0]       out_end_bus,
  output logic [ert_pkg::COUNT_W-1:0]     entry_count
);

  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  ert_pkg::carry_t    carry_link [0:MAX_RANGES];
  ert_pkg::cell_ctl_t cell_ctl   [0:MAX_RANGES-1];
  ert_pkg::carry_t    head;
  ert_pkg::carry_t    tail;
  ert_pkg::entry_t    wr_entry;
  logic [MAX_RANGES-1:0] valid_vec;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             full_next;
  logic             busy;
  logic             in_acc;
  logic             drain;
  logic             advance;
  logic             ins_ok;

  logic [ert_pkg::STATUS_W-1:0] status_next;
  logic [ert_pkg::ADDR_W-1:0]   base_next;
  logic [ert_pkg::SEG_W-1:0]    seg_next;
  logic [ert_pkg::BUS_W-1:0]    sbus_next;
  logic [ert_pkg::BUS_W-1:0]    ebus_next;

  // Handshake and chain flow.
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign tail     = carry_link[MAX_RANGES];
  assign drain    = tail.valid && (!out_valid || !out_stall);
  assign advance  = !tail.valid || drain;

  // Build the token from the input transaction.
  always_comb begin
    head          = '0;
    head.valid    = in_acc;
    head.mode     = mode;
    head.bad      = (base_addr == '0) || (base_addr[ert_pkg::ALIGN_W-1:0] != '0) ||
                    (first_bus > end_bus);
    head.base_hi  = base_addr[ert_pkg::ADDR_W-1:ert_pkg::ALIGN_W];
    head.seg      = segment;
    head.sbus     = first_bus;
    head.ebus     = end_bus;
    head.bus      = bus;
    head.idx      = index;
  end

  assign carry_link[0] = head;

  // Entry written at the slot after the last stored one.
  assign wr_entry.base_hi = tail.base_hi;
  assign wr_entry.seg     = tail.seg;
  assign wr_entry.sbus    = tail.sbus;
  assign wr_entry.ebus    = tail.ebus;

  // Cell chain.
  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    assign cell_ctl[i].advance  = advance;
    assign cell_ctl[i].occupied = (CNT_W'(i) < count);
    assign cell_ctl[i].wr_sel   = drain && ins_ok && (count == CNT_W'(i));
    assign valid_vec[i]         = carry_link[i+1].valid;

    ert_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[i]),
      .wr_entry (wr_entry),
      .carry_in (carry_link[i]),
      .carry_out(carry_link[i+1])
    );
  end

  // Resolve the transaction at the chain end.
  always_comb begin
    status_next = ert_pkg::ST_OK;
    base_next   = '0;
    seg_next    = '0;
    sbus_next   = '0;
    ebus_next   = '0;
    count_next  = count;
    full_next   = full;
    ins_ok      = 1'b0;
    unique case (tail.mode)
      ert_pkg::MODE_CLEAR: begin
        count_next = '0;
        full_next  = 1'b0;
      end
      ert_pkg::MODE_INSERT: begin
        if (full) begin
          status_next = ert_pkg::ST_FULL;
        end else if (tail.bad) begin
          status_next = ert_pkg::ST_INVALID;
        end else if (tail.clash) begin
          status_next = ert_pkg::ST_OVERLAP;
        end else if (count >= CNT_W'(MAX_RANGES)) begin
          full_next   = 1'b1;
          status_next = ert_pkg::ST_FULL;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ert_pkg::MODE_LOOKUP, ert_pkg::MODE_READ: begin
        if (tail.hit) begin
          base_next = {tail.hit_base, {ert_pkg::ALIGN_W{1'b0}}};
          seg_next  = tail.hit_seg;
          sbus_next = tail.hit_sbus;
          ebus_next = tail.hit_ebus;
        end else begin
          status_next = ert_pkg::ST_MISS;
        end
      end
      default: begin
        status_next = ert_pkg::ST_OK;
      end
    endcase
  end

  // Update table state and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      full  <= 1'b0;
      busy  <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (drain) begin
        busy <= 1'b0;
      end
      if (drain) begin
        count <= count_next;
        full  <= full_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      status        <= status_next;
      out_base      <= base_next;
      out_segment   <= seg_next;
      out_start_bus <= sbus_next;
      out_end_bus   <= ebus_next;
      entry_count   <= ert_pkg::COUNT_W'(count_next);
    end
  end

  // At most one token travels the chain.
  assert property (@(posedge clk) disable iff (rst) $countones(valid_vec) <= 1)
    else $error("more than one token in the cell chain");

  // The full mark is only set with a full table.
  assert property (@(posedge clk) disable iff (rst) full |-> (count == CNT_W'(MAX_RANGES)))
    else $error("full mark set with room left");

  // The entry count stays within the table.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_RANGES))
    else $error("entry count beyond table depth");

  // A drained token always shows up at the output.
  assert property (@(posedge clk) disable iff (rst) drain |=> out_valid)
    else $error("resolved transaction lost");

endmodule
